[design/matrix_chain_order_cost_core_macros.svh]
// Assertion macros for the port-level checker of the chain cost core.
// Depends on nothing; included by the checker.
`ifndef MATRIX_CHAIN_ORDER_COST_CORE_MACROS_SVH
`define MATRIX_CHAIN_ORDER_COST_CORE_MACROS_SVH

// same-cycle implication
`define MCOC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcoc assertion failed");

// next-cycle implication
`define MCOC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcoc assertion failed");

`endif

[design/mcoc_pkg.sv]
// Shared types, constants and saturating add for the chain cost core.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps

package mcoc_pkg;

   localparam int COST_BITS = 40;

   typedef logic [COST_BITS-1:0] cost_type;

   localparam cost_type COST_MAX = '1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_HEAD,
      ST_ISSUE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   function automatic cost_type sat_add(cost_type a, cost_type b);
      logic [COST_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COST_BITS] ? COST_MAX : s[COST_BITS-1:0];
   endfunction

endpackage

[design/mcoc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the dimension and cost tables.
`timescale 1ns / 1ps

module mcoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/matrix_chain_order_cost_core.sv]
// Matrix chain order cost: least scalar multiplication count of a chain.
// Uses mcoc_pkg and mcoc_ram.
//
// Input channel req_*: one beat per matrix (rows, cols, last_matrix). The first
// beat's rows and every beat's cols are stored as the dimension vector; beats
// past MAX_MATRICES are dropped and flag overflow. Beats after the first are
// taken back to back; the first also passes a head state that stores its cols.
// After the beat with last_matrix set, req_ready drops while the cost table is
// filled: one split per cycle in the issue state through a three-stage
// read/multiply/compare pipeline on the cost RAM, with a drain state between
// chain lengths so the next length reads finished entries.
// Result channel rsp_*: one beat per chain (min_cost, overflow), held in an
// output register. A new chain loads while a result waits; a finished chain
// waits in its last state until the receiver takes the previous result.
// Reset (synchronous) empties the chain and drops any pending result; table
// contents need no clearing.
`timescale 1ns / 1ps

module matrix_chain_order_cost_core import mcoc_pkg::*; #(
   parameter int MAX_MATRICES = 16,
   parameter int DIM_BITS     = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [DIM_BITS-1:0]  req_rows,
   input  logic [DIM_BITS-1:0]  req_cols,
   input  logic                 req_last_matrix,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COST_BITS-1:0] rsp_min_cost,
   output logic                 rsp_overflow
);

   localparam int IDXW   = $clog2(MAX_MATRICES);
   localparam int CNTW   = $clog2(MAX_MATRICES + 1);
   localparam int CDEPTH = 1 << (2 * IDXW);
   localparam int PW     = 3 * DIM_BITS;
   localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_MATRICES);

   typedef struct packed {
      logic            valid;
      logic            first;
      logic            last;
      logic [IDXW-1:0] row;
      logic [IDXW-1:0] col;
   } step_type;

   state_type state_ff, state_in;

   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic [DIM_BITS-1:0] head_cols_ff, head_cols_in;
   logic                head_last_ff, head_last_in;
   logic [CNTW-1:0]     len_ff, len_in;
   logic [IDXW-1:0]     row_ff, row_in;
   logic [IDXW-1:0]     split_ff, split_in;
   logic [1:0]          drain_ff, drain_in;
   cost_type            res_ff;
   cost_type            best_ff;

   logic                 rsp_valid_ff;
   logic [COST_BITS-1:0] rsp_min_cost_ff;
   logic                 rsp_overflow_ff;

   logic accept, room, is_first, out_free;
   logic [CNTW-1:0] col_w;
   logic [IDXW-1:0] col, split_nx;
   logic split_end, cell_end, len_end;

   logic                dim_we;
   logic [CNTW-1:0]     dim_wa;
   logic [DIM_BITS-1:0] dim_wd;
   logic                diag_we, issue, zero_res, done_fire;

   logic                cost_we;
   logic [2*IDXW-1:0]   cost_wa;
   cost_type            cost_wd;
   cost_type            cost_a_q, cost_b_q;
   logic [DIM_BITS-1:0] dim_i_q, dim_k_q, dim_j_q;

   step_type              st1_in, st1_ff, st2_ff, st3_ff;
   logic [2*DIM_BITS-1:0] pij, p2_ff;
   logic [DIM_BITS-1:0]   dk2_ff;
   cost_type              sum_ik, sum2_ff, sum3_ff;
   logic [PW-1:0]         prod;
   logic [PW+COST_BITS-1:0] prod_ext;
   cost_type              prod_sat, prod3_ff;
   cost_type              c_split, cand;

   assign accept   = req_valid && req_ready;
   assign room     = cnt_ff != MAX_CNT;
   assign is_first = cnt_ff == '0;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign col_w     = CNTW'(row_ff) + len_ff - CNTW'(1);
   assign col       = col_w[IDXW-1:0];
   assign split_nx  = split_ff + IDXW'(1);
   assign split_end = (CNTW'(split_ff) + CNTW'(1)) == col_w;
   assign cell_end  = (CNTW'(row_ff) + len_ff) == cnt_ff;
   assign len_end   = len_ff == cnt_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (is_first) begin
                  state_in = ST_HEAD;
               end else if (req_last_matrix) begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_HEAD: begin
            state_in = head_last_ff ? ST_DONE : ST_LOAD;
         end
         ST_ISSUE: begin
            if (split_end && cell_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == 2'd2) begin
               state_in = len_end ? ST_DONE : ST_ISSUE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      dim_we       = 1'b0;
      dim_wa       = '0;
      dim_wd       = '0;
      diag_we      = 1'b0;
      issue        = 1'b0;
      zero_res     = 1'b0;
      done_fire    = 1'b0;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      head_cols_in = head_cols_ff;
      head_last_in = head_last_ff;
      len_in       = len_ff;
      row_in       = row_ff;
      split_in     = split_ff;
      drain_in     = drain_ff;
      case (state_ff)
         ST_LOAD: begin
            req_ready    = 1'b1;
            head_cols_in = req_cols;
            head_last_in = req_last_matrix;
            len_in       = CNTW'(2);
            row_in       = '0;
            split_in     = '0;
            if (accept) begin
               if (room) begin
                  cnt_in  = cnt_ff + CNTW'(1);
                  diag_we = 1'b1;
                  dim_we  = 1'b1;
                  dim_wa  = is_first ? '0 : cnt_ff + CNTW'(1);
                  dim_wd  = is_first ? req_rows : req_cols;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_HEAD: begin
            dim_we   = 1'b1;
            dim_wa   = CNTW'(1);
            dim_wd   = head_cols_ff;
            zero_res = 1'b1;
         end
         ST_ISSUE: begin
            issue = 1'b1;
            if (split_end) begin
               if (cell_end) begin
                  drain_in = '0;
               end else begin
                  row_in   = row_ff + IDXW'(1);
                  split_in = row_ff + IDXW'(1);
               end
            end else begin
               split_in = split_nx;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd2 && !len_end) begin
               len_in   = len_ff + CNTW'(1);
               row_in   = '0;
               split_in = '0;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               done_fire = 1'b1;
               cnt_in    = '0;
               ovf_in    = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // dimension vector, one copy per read address
   mcoc_ram #(.WIDTH(DIM_BITS), .DEPTH(MAX_MATRICES + 1)) u_dim_i (
      .clock(clock), .wr_en(dim_we), .wr_addr(dim_wa), .wr_data(dim_wd),
      .rd_addr(CNTW'(row_ff)), .rd_data(dim_i_q)
   );

   mcoc_ram #(.WIDTH(DIM_BITS), .DEPTH(MAX_MATRICES + 1)) u_dim_k (
      .clock(clock), .wr_en(dim_we), .wr_addr(dim_wa), .wr_data(dim_wd),
      .rd_addr(CNTW'(split_ff) + CNTW'(1)), .rd_data(dim_k_q)
   );

   mcoc_ram #(.WIDTH(DIM_BITS), .DEPTH(MAX_MATRICES + 1)) u_dim_j (
      .clock(clock), .wr_en(dim_we), .wr_addr(dim_wa), .wr_data(dim_wd),
      .rd_addr(col_w + CNTW'(1)), .rd_data(dim_j_q)
   );

   // cost table, two copies for the left and right operand reads
   assign cost_we = diag_we || (st3_ff.valid && st3_ff.last);
   assign cost_wa = diag_we ? {cnt_ff[IDXW-1:0], cnt_ff[IDXW-1:0]} : {st3_ff.row, st3_ff.col};
   assign cost_wd = diag_we ? '0 : cand;

   mcoc_ram #(.WIDTH(COST_BITS), .DEPTH(CDEPTH)) u_cost_a (
      .clock(clock), .wr_en(cost_we), .wr_addr(cost_wa), .wr_data(cost_wd),
      .rd_addr({row_ff, split_ff}), .rd_data(cost_a_q)
   );

   mcoc_ram #(.WIDTH(COST_BITS), .DEPTH(CDEPTH)) u_cost_b (
      .clock(clock), .wr_en(cost_we), .wr_addr(cost_wa), .wr_data(cost_wd),
      .rd_addr({split_nx, col}), .rd_data(cost_b_q)
   );

   assign st1_in = '{valid: issue, first: split_ff == row_ff, last: split_end,
                     row: row_ff, col: col};

   assign pij    = (2*DIM_BITS)'(dim_i_q) * (2*DIM_BITS)'(dim_j_q);
   assign sum_ik = sat_add(cost_a_q, cost_b_q);

   assign prod     = PW'(p2_ff) * PW'(dk2_ff);
   assign prod_ext = {{COST_BITS{1'b0}}, prod};
   assign prod_sat = (|prod_ext[PW+COST_BITS-1:COST_BITS]) ? COST_MAX
                                                          : prod_ext[COST_BITS-1:0];

   assign c_split = sat_add(sum3_ff, prod3_ff);
   assign cand    = (st3_ff.first || c_split < best_ff) ? c_split : best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         len_ff       <= CNTW'(2);
         row_ff       <= '0;
         split_ff     <= '0;
         drain_ff     <= '0;
         st1_ff       <= '0;
         st2_ff       <= '0;
         st3_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         len_ff   <= len_in;
         row_ff   <= row_in;
         split_ff <= split_in;
         drain_ff <= drain_in;
         st1_ff   <= st1_in;
         st2_ff   <= st1_ff;
         st3_ff   <= st2_ff;
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_cols_ff <= head_cols_in;
      head_last_ff <= head_last_in;
      p2_ff        <= pij;
      dk2_ff       <= dim_k_q;
      sum2_ff      <= sum_ik;
      prod3_ff     <= prod_sat;
      sum3_ff      <= sum2_ff;
      if (st3_ff.valid) begin
         best_ff <= cand;
      end
      if (st3_ff.valid && st3_ff.last) begin
         res_ff <= cand;
      end else if (zero_res) begin
         res_ff <= '0;
      end
      if (done_fire) begin
         rsp_min_cost_ff <= res_ff;
         rsp_overflow_ff <= ovf_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_min_cost = rsp_min_cost_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

[design/mcoc_checker.sv]
// Port-level checker for the chain cost core, bound to the top level.
// Uses mcoc_pkg and matrix_chain_order_cost_core_macros.svh.
`timescale 1ns / 1ps
`include "matrix_chain_order_cost_core_macros.svh"

module mcoc_checker import mcoc_pkg::*; #(
   parameter int DIM_BITS = 12
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [DIM_BITS-1:0]  req_rows,
   input logic [DIM_BITS-1:0]  req_cols,
   input logic                 req_last_matrix,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [COST_BITS-1:0] rsp_min_cost,
   input logic                 rsp_overflow
);

   // a stalled result beat holds
   `MCOC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_min_cost) && $stable(rsp_overflow))

   // closing a chain stops intake while the table fills
   `MCOC_ASSERT_NEXT(a_last_stalls, clock, reset, req_valid && req_ready && req_last_matrix, !req_ready)

   // a new result only comes out of a busy cycle
   `MCOC_ASSERT_IMPL(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))

   // reset leaves the block empty and ready
   `MCOC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready)

endmodule

bind matrix_chain_order_cost_core mcoc_checker #(.DIM_BITS(DIM_BITS)) u_mcoc_checker (.*);

[bench/chain_cost_checker.sv]
// Checker for matrix_chain_order_cost_core: watches both channels, predicts each chain's
// least multiplication count and compares it with every result beat. Uses mcoc_pkg types.
`timescale 1ns / 1ps

module chain_cost_checker import mcoc_pkg::*; #(
   parameter int MAX_MATRICES = 16,
   parameter int DIM_BITS     = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [DIM_BITS-1:0]  req_rows,
   input  logic [DIM_BITS-1:0]  req_cols,
   input  logic                 req_last_matrix,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [COST_BITS-1:0] rsp_min_cost,
   input  logic                 rsp_overflow,
   output int                   chains_waiting,
   output int                   fail_count
);

   typedef struct packed {
      cost_type cost;
      logic     overflow;
   } chain_result_type;

   logic [DIM_BITS-1:0] dims [0:MAX_MATRICES];
   int unsigned         stored;
   logic                dropped;
   chain_result_type    expected_chains [$];

   initial begin
      fail_count     = 0;
      chains_waiting = 0;
      stored         = 0;
      dropped        = 1'b0;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic cost_type clip_sum(cost_type a, cost_type b);
      logic [COST_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COST_BITS] ? COST_MAX : s[COST_BITS-1:0];
   endfunction

   function automatic cost_type split_product(int a, int b, int c);
      logic [63:0] p;
      p = 64'(dims[a]) * 64'(dims[b]) * 64'(dims[c]);
      return (p > 64'(COST_MAX)) ? COST_MAX : p[COST_BITS-1:0];
   endfunction

   // bottom-up DP over chain lengths; first minimal split kept
   function automatic cost_type best_order_cost(int n);
      cost_type tbl [0:MAX_MATRICES-1][0:MAX_MATRICES-1];
      cost_type best;
      cost_type trial;
      int       j;
      for (int i = 0; i < n; i++) tbl[i][i] = '0;
      for (int len = 2; len <= n; len++) begin
         for (int i = 0; i + len <= n; i++) begin
            j    = i + len - 1;
            best = COST_MAX;
            for (int k = i; k < j; k++) begin
               trial = clip_sum(clip_sum(tbl[i][k], tbl[k+1][j]), split_product(i, k + 1, j + 1));
               if (k == i || trial < best) best = trial;
            end
            tbl[i][j] = best;
         end
      end
      return tbl[0][n-1];
   endfunction

   always @(posedge clock) begin
      chain_result_type want;
      if (reset) begin
         stored  = 0;
         dropped = 1'b0;
         expected_chains.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chains.size() == 0) begin
               report("result beat with no chain pending", 64'(rsp_min_cost), 64'(0));
            end else begin
               want = expected_chains.pop_front();
               if (rsp_min_cost !== want.cost)
                  report("min_cost", 64'(rsp_min_cost), 64'(want.cost));
               if (rsp_overflow !== want.overflow)
                  report("overflow", 64'(rsp_overflow), 64'(want.overflow));
            end
         end
         if (req_valid && req_ready) begin
            if (stored == 0) dims[0] = req_rows;
            if (stored < MAX_MATRICES) begin
               dims[stored+1] = req_cols;
               stored++;
            end else begin
               dropped = 1'b1;
            end
            if (req_last_matrix) begin
               want.cost     = best_order_cost(stored);
               want.overflow = dropped;
               expected_chains.push_back(want);
               stored  = 0;
               dropped = 1'b0;
            end
         end
      end
      chains_waiting = expected_chains.size();
   end

endmodule

[bench/tb.sv]
// Testbench top for matrix_chain_order_cost_core: drives matrix beats in bursts, stalls the
// result side, and gives the verdict. Needs mcoc_pkg, the core and chain_cost_checker.
`timescale 1ns / 1ps

module tb import mcoc_pkg::*; ();

   localparam int MAX_MATRICES  = 16;
   localparam int DIM_BITS      = 12;
   localparam logic [DIM_BITS-1:0] DIM_TOP = '1;
   localparam int RANDOM_ITEMS  = 1550;
   localparam int HOLD_CYCLES   = 3000;
   localparam int SETTLE_CYCLES = 1000;

   typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [DIM_BITS-1:0]  req_rows;
   logic [DIM_BITS-1:0]  req_cols;
   logic                 req_last_matrix;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [COST_BITS-1:0] rsp_min_cost;
   logic                 rsp_overflow;

   int          chains_waiting;
   int          fail_count;
   int          burst_left;
   int          items_sent;
   int          chains_sent;
   int          seg_left;
   rx_mode_type rx_mode;
   bit          hold_req;
   bit          hold_done;

   matrix_chain_order_cost_core #(
      .MAX_MATRICES(MAX_MATRICES),
      .DIM_BITS    (DIM_BITS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rows       (req_rows),
      .req_cols       (req_cols),
      .req_last_matrix(req_last_matrix),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_min_cost   (rsp_min_cost),
      .rsp_overflow   (rsp_overflow)
   );

   chain_cost_checker #(
      .MAX_MATRICES(MAX_MATRICES),
      .DIM_BITS    (DIM_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rows       (req_rows),
      .req_cols       (req_cols),
      .req_last_matrix(req_last_matrix),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_min_cost   (rsp_min_cost),
      .rsp_overflow   (rsp_overflow),
      .chains_waiting (chains_waiting),
      .fail_count     (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("tb NOT OK");
      $finish;
   end

   function automatic logic [DIM_BITS-1:0] pick_dim();
      case ($urandom_range(0, 19))
         0, 1:    return DIM_TOP;
         2, 3:    return DIM_BITS'(1);
         4:       return '0;
         5, 6, 7: return DIM_BITS'($urandom_range(1, 16));
         default: return DIM_BITS'($urandom_range(1, DIM_TOP));
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_matrix(input logic [DIM_BITS-1:0] rows, input logic [DIM_BITS-1:0] cols,
                              input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_rows        <= rows;
      req_cols        <= cols;
      req_last_matrix <= last;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_chain(input int n, input bit all_max);
      logic [DIM_BITS-1:0] rows;
      logic [DIM_BITS-1:0] cols;
      for (int m = 0; m < n; m++) begin
         rows = (m == 0) ? (all_max ? DIM_TOP : pick_dim())
                         : DIM_BITS'($urandom_range(0, DIM_TOP));
         cols = all_max ? DIM_TOP : pick_dim();
         send_matrix(rows, cols, m == n - 1);
      end
      items_sent += n;
      chains_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (chains_waiting != 0);
   endtask

   // receiver: rsp_ready pattern changes mode every segment; one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      seg_left  = 0;
      rx_mode   = RX_STEADY;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if (seg_left == 0) begin
               rx_mode  = rx_mode_type'($urandom_range(0, 3));
               seg_left = $urandom_range(10, 150);
            end
            seg_left--;
            case (rx_mode)
               RX_STEADY: rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   initial begin
      int r;
      int n;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_rows        = '0;
      req_cols        = '0;
      req_last_matrix = 1'b0;
      burst_left      = 0;
      items_sent      = 0;
      chains_sent     = 0;
      hold_req        = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single matrix, max dims
      send_matrix(DIM_TOP, DIM_TOP, 1'b1);
      // unit dims, mismatched rows on the second matrix
      send_matrix(DIM_BITS'(1), DIM_BITS'(1), 1'b0);
      send_matrix(DIM_TOP, DIM_BITS'(1), 1'b1);
      // zero dimensions
      send_matrix('0, DIM_TOP, 1'b0);
      send_matrix(DIM_BITS'(1234), '0, 1'b0);
      send_matrix(DIM_BITS'(1), DIM_TOP, 1'b1);
      // two max matrices
      send_matrix(DIM_TOP, DIM_TOP, 1'b0);
      send_matrix('0, DIM_TOP, 1'b1);
      // one past capacity; the dropped matrix closes the chain
      send_chain(MAX_MATRICES + 1, 1'b0);
      wait_drained();

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 8)       n = 1;
         else if (r < 70) n = $urandom_range(2, 8);
         else if (r < 93) n = $urandom_range(9, MAX_MATRICES);
         else             n = $urandom_range(MAX_MATRICES + 1, MAX_MATRICES + 4);
         if ($urandom_range(0, 39) == 0) send_chain(MAX_MATRICES, 1'b1);
         else                            send_chain(n, 1'b0);
         if (chains_sent == 30) hold_req = 1'b1;
         if (chains_sent == 60 || $urandom_range(0, 29) == 0) wait_drained();
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (chains_waiting != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/mcoc_pkg.sv
design/mcoc_ram.sv
design/matrix_chain_order_cost_core.sv
design/mcoc_checker.sv
bench/chain_cost_checker.sv
bench/tb.sv
